// ===== design/hmmc_pkg.sv =====
package hmmc_pkg;

  typedef enum logic [2:0] {
    OP_RD_BYTE  = 3'd0,
    OP_WR_BYTE  = 3'd1,
    OP_RD_WORD  = 3'd2,
    OP_WR_WORD  = 3'd3,
    OP_LD_CART  = 3'd4,
    OP_LD_BOOT  = 3'd5,
    OP_RESTART  = 3'd6,
    OP_NOP      = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_DMA_RD,
    ST_DMA_WR,
    ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    RG_BOOT,
    RG_CART,
    RG_VRAM,
    RG_WRAM,
    RG_OAM,
    RG_IO,
    RG_JOY,
    RG_DIV,
    RG_HRAM,
    RG_IE,
    RG_ZERO
  } region_e;

  localparam logic [7:0] DmaLen = 8'hA0;

  typedef struct packed {
    region_e     region;
    logic [14:0] offset;
  } decode_t;

  function automatic decode_t decode(input logic [15:0] addr, input logic boot);
    decode_t     d;
    logic [15:0] a;
    a = addr;
    if (a >= 16'hE000 && a < 16'hFE00) a = a - 16'h2000;
    d.offset = a[14:0];
    if (boot && a <= 16'h00FF)      d.region = RG_BOOT;
    else if (a < 16'h8000)          d.region = RG_CART;
    else if (a < 16'hA000)          d.region = RG_VRAM;
    else if (a < 16'hC000)          d.region = RG_ZERO;
    else if (a < 16'hE000)          d.region = RG_WRAM;
    else if (a < 16'hFE00)          d.region = RG_ZERO;
    else if (a < 16'hFEA0)          d.region = RG_OAM;
    else if (a < 16'hFF00)          d.region = RG_ZERO;
    else if (a == 16'hFF00)         d.region = RG_JOY;
    else if (a == 16'hFF04)         d.region = RG_DIV;
    else if (a < 16'hFF80)          d.region = RG_IO;
    else if (a < 16'hFFFF)          d.region = RG_HRAM;
    else                            d.region = RG_IE;
    return d;
  endfunction

endpackage

// ===== design/handheld_memory_map_controller.sv =====
// One transfer at a time: busy stays high through the done_o cycle; an OAM copy does one
//   read and one write per byte. done_o lasts one cycle and the receiver cannot stall.
// Reset clears io registers, IE, boot mode and the config bit; other stores are
//   undefined until written.
module handheld_memory_map_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  output logic        done_o,
  input  logic [2:0]  operation_i,
  input  logic [15:0] address_i,
  input  logic [15:0] data_i,
  input  logic [7:0]  joypad_p1_i,
  input  logic [15:0] timer_divider_i,
  output logic [15:0] read_data_o,
  output logic        div_reset_o,
  output logic        tac_write_o,
  output logic [7:0]  tac_value_o,
  output logic        ly_reset_o,
  output logic        reset_request_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hmmc_pkg::*;

  logic [7:0] cart_mem [32768];
  logic [7:0] boot_mem [256];
  logic [7:0] vram_mem [8192];
  logic [7:0] wram_mem [8192];
  logic [7:0] oam_mem  [160];
  logic [7:0] io_mem   [128];
  logic [7:0] hram_mem [127];
  logic [127:0] io_vld_q;

  state_e      state_q, state_d;
  op_e         op_q;
  logic [15:0] addr_q, data_q, div_q;
  logic [7:0]  joy_q;
  logic        second_q, second_d;
  logic [7:0]  dma_cnt_q, dma_cnt_d;
  logic [7:0]  lo_q, lo_d;
  logic [15:0] rd_q, rd_d;
  logic        div_rst_q, div_rst_d, tac_wr_q, tac_wr_d, ly_rst_q, ly_rst_d;
  logic        rst_req_q, rst_req_d;
  logic [7:0]  tac_val_q, tac_val_d;
  logic        boot_q, boot_d, use_boot_q;
  logic [7:0]  ie_q, ie_d;

  logic [15:0] acc_addr;
  logic [7:0]  wr_byte;
  decode_t     dec;
  region_e     reg_q;
  logic [7:0]  cart_rd, boot_rd, vram_rd, wram_rd, oam_rd, io_rd, hram_rd;
  logic [7:0]  fixed_q;
  logic [7:0]  rd_byte;
  logic [6:0]  io_idx_q;
  logic        is_write, mem_we, is_dma_copy;

  assign pready = 1'b1;
  assign prdata = {31'd0, use_boot_q};
  assign busy   = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) use_boot_q <= 1'b0;
    else if (psel && penable && pwrite && paddr == 2'd0) use_boot_q <= pwdata[0];
  end

  // access address for the current byte
  always_comb begin
    wr_byte = second_q ? data_q[15:8] : data_q[7:0];
    if (state_q == ST_DMA_RD || state_q == ST_DMA_WR) begin
      acc_addr = {wr_byte, dma_cnt_q};
    end else begin
      acc_addr = addr_q + {15'd0, second_q};
    end
    dec     = decode(acc_addr, boot_q);
    is_write = (op_q == OP_WR_BYTE) || (op_q == OP_WR_WORD);
  end

  // memory reads, registered
  always_ff @(posedge clk_i) begin
    cart_rd <= cart_mem[acc_addr[14:0]];
    boot_rd <= boot_mem[acc_addr[7:0]];
    vram_rd <= vram_mem[acc_addr[12:0]];
    wram_rd <= wram_mem[acc_addr[12:0]];
    oam_rd  <= oam_mem[acc_addr[7:0] < DmaLen ? acc_addr[7:0] : 8'd0];
    io_rd   <= io_mem[acc_addr[6:0]];
    hram_rd <= hram_mem[acc_addr[6:0] == 7'h7F ? 7'd0 : acc_addr[6:0]];
    reg_q   <= dec.region;
    io_idx_q <= acc_addr[6:0];
    fixed_q <= (dec.region == RG_JOY) ? joy_q :
               (dec.region == RG_DIV) ? div_q[15:8] :
               (dec.region == RG_IE)  ? ie_q : 8'd0;
  end

  always_comb begin
    case (reg_q)
      RG_BOOT: rd_byte = boot_rd;
      RG_CART: rd_byte = cart_rd;
      RG_VRAM: rd_byte = vram_rd;
      RG_WRAM: rd_byte = wram_rd;
      RG_OAM:  rd_byte = oam_rd;
      RG_IO:   rd_byte = io_vld_q[io_idx_q] ? io_rd : 8'd0;
      RG_HRAM: rd_byte = hram_rd;
      RG_JOY, RG_DIV, RG_IE: rd_byte = fixed_q;
      default: rd_byte = 8'd0;
    endcase
  end

  // byte write at ST_ISSUE for writes (not special io), DMA writes in ST_DMA_WR
  logic [14:0] wr_off;
  logic [7:0]  wr_val;
  region_e     wr_reg;
  always_comb begin
    is_dma_copy = (state_q == ST_DMA_WR);
    mem_we = 1'b0;
    wr_reg = dec.region;
    wr_off = dec.offset;
    wr_val = wr_byte;
    if (is_dma_copy) begin
      mem_we = 1'b1;
      wr_reg = RG_OAM;
      wr_off = {7'd0, dma_cnt_q};
      wr_val = rd_byte;
    end else if (state_q == ST_ISSUE && is_write && dec.region != RG_BOOT) begin
      mem_we = !(acc_addr == 16'hFF04 || acc_addr == 16'hFF07 ||
                 acc_addr == 16'hFF44 || acc_addr == 16'hFF46);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_ISSUE && op_q == OP_LD_CART && !addr_q[15])
      cart_mem[addr_q[14:0]] <= data_q[7:0];
    if (state_q == ST_ISSUE && op_q == OP_LD_BOOT && addr_q[15:8] == 8'd0)
      boot_mem[addr_q[7:0]] <= data_q[7:0];
    if (mem_we) begin
      case (wr_reg)
        RG_VRAM: vram_mem[wr_off[12:0]] <= wr_val;
        RG_WRAM: wram_mem[wr_off[12:0]] <= wr_val;
        RG_OAM:  oam_mem[wr_off[7:0]]   <= wr_val;
        RG_IO, RG_JOY, RG_DIV: io_mem[wr_off[6:0]] <= wr_val;
        RG_HRAM: hram_mem[wr_off[6:0]]  <= wr_val;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) io_vld_q <= '0;
    else if (mem_we && (wr_reg == RG_IO || wr_reg == RG_JOY || wr_reg == RG_DIV))
      io_vld_q[wr_off[6:0]] <= 1'b1;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (start) state_d = ST_ISSUE;
      ST_ISSUE: begin
        if (is_write && acc_addr == 16'hFF46) state_d = ST_DMA_RD;
        else if (op_q == OP_RD_BYTE || op_q == OP_RD_WORD) state_d = ST_WAIT;
        else if (op_q == OP_WR_WORD && !second_q) state_d = ST_ISSUE;
        else state_d = ST_DONE;
      end
      ST_WAIT:   state_d = (op_q == OP_RD_WORD && !second_q) ? ST_ISSUE : ST_DONE;
      ST_DMA_RD: state_d = ST_DMA_WR;
      ST_DMA_WR: begin
        if (dma_cnt_q != DmaLen - 8'd1) state_d = ST_DMA_RD;
        else if (op_q == OP_WR_WORD && !second_q) state_d = ST_ISSUE;
        else state_d = ST_DONE;
      end
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    second_d = second_q;  dma_cnt_d = dma_cnt_q; lo_d = lo_q; rd_d = rd_q;
    div_rst_d = div_rst_q; tac_wr_d = tac_wr_q; tac_val_d = tac_val_q;
    ly_rst_d = ly_rst_q; rst_req_d = rst_req_q; boot_d = boot_q; ie_d = ie_q;
    case (state_q)
      ST_IDLE: begin
        second_d = 1'b0; dma_cnt_d = 8'd0; rd_d = '0;
        div_rst_d = 1'b0; tac_wr_d = 1'b0; tac_val_d = 8'd0;
        ly_rst_d = 1'b0; rst_req_d = 1'b0;
      end
      ST_ISSUE: begin
        if (op_q == OP_RESTART) begin
          if (use_boot_q) boot_d = 1'b1;
          else rst_req_d = 1'b1;
        end
        if (is_write) begin
          if (acc_addr == 16'hFF04) div_rst_d = 1'b1;
          if (acc_addr == 16'hFF07) begin tac_wr_d = 1'b1; tac_val_d = wr_byte; end
          if (acc_addr == 16'hFF44) ly_rst_d = 1'b1;
          if (acc_addr == 16'hFF50 && boot_q) begin boot_d = 1'b0; rst_req_d = 1'b1; end
          if (dec.region == RG_IE) ie_d = wr_byte;
          if (acc_addr == 16'hFF46) dma_cnt_d = 8'd0;
          else if (op_q == OP_WR_WORD) second_d = 1'b1;
        end
      end
      ST_WAIT: begin
        if (second_q) rd_d = {rd_byte, lo_q};
        else begin rd_d = {8'd0, rd_byte}; lo_d = rd_byte; second_d = 1'b1; end
      end
      ST_DMA_WR: begin
        dma_cnt_d = dma_cnt_q + 8'd1;
        if (dma_cnt_q == DmaLen - 8'd1 && op_q == OP_WR_WORD) second_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; boot_q <= 1'b0; ie_q <= 8'd0;
      second_q <= 1'b0; dma_cnt_q <= 8'd0;
      div_rst_q <= 1'b0; tac_wr_q <= 1'b0; ly_rst_q <= 1'b0; rst_req_q <= 1'b0;
    end else begin
      state_q <= state_d; boot_q <= boot_d; ie_q <= ie_d;
      second_q <= second_d; dma_cnt_q <= dma_cnt_d;
      div_rst_q <= div_rst_d; tac_wr_q <= tac_wr_d; ly_rst_q <= ly_rst_d;
      rst_req_q <= rst_req_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d; rd_q <= rd_d; tac_val_q <= tac_val_d;
    if (state_q == ST_IDLE && start) begin
      op_q <= op_e'(operation_i); addr_q <= address_i; data_q <= data_i;
      joy_q <= joypad_p1_i; div_q <= timer_divider_i;
    end
  end

  assign done_o          = (state_q == ST_DONE);
  assign read_data_o     = rd_q;
  assign div_reset_o     = div_rst_q;
  assign tac_write_o     = tac_wr_q;
  assign tac_value_o     = tac_val_q;
  assign ly_reset_o      = ly_rst_q;
  assign reset_request_o = rst_req_q;

`ifndef SYNTH
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_dma_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DMA_RD) |-> (dma_cnt_q < DmaLen)) else $error("dma overrun");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("start lost");
`endif
endmodule
